// ===== rtl/edsu_pkg.sv =====
// Shared types and codes for the edit distance similarity unit.
package edsu_pkg;

    typedef enum logic [1:0] {
        CMD_FIRST   = 2'd0,
        CMD_SECOND  = 2'd1,
        CMD_COMPUTE = 2'd2
    } op_t;

    localparam int FRAC_W = 16;
    localparam int DIST_W = 6;
    localparam int SIM_W  = 17;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW_FETCH,
        ST_ROW_RUN,
        ST_DIV_SETUP,
        ST_DIV_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_first;
        logic load_second;
        logic start;
        logic row_fetch;
        logic calc;
        logic row_next;
        logic div_setup;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic first_empty;
        logic second_empty;
        logic col_last;
        logic row_last;
        logic div_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/edsu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module edsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/edsu_ctrl.sv =====
// Controller state machine: sequences loads, the DP sweep, the divider and the result.
module edsu_ctrl
    import edsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] cmd,
    output logic       in_stall,
    output dp_cmd_t    dp_cmd,
    input  dp_stat_t   dp_stat
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    case (cmd)
                        CMD_FIRST:   dp_cmd.load_first  = 1'b1;
                        CMD_SECOND:  dp_cmd.load_second = 1'b1;
                        CMD_COMPUTE:
                        begin
                            dp_cmd.start = 1'b1;
                            // skip the sweep when either word is empty
                            if (dp_stat.first_empty || dp_stat.second_empty)
                            begin
                                state_next = ST_DIV_SETUP;
                            end
                            else
                            begin
                                state_next = ST_ROW_FETCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_ROW_FETCH:
            begin
                dp_cmd.row_fetch = 1'b1;
                state_next       = ST_ROW_RUN;
            end
            ST_ROW_RUN:
            begin
                dp_cmd.calc = 1'b1;
                if (dp_stat.col_last)
                begin
                    if (dp_stat.row_last)
                    begin
                        state_next = ST_DIV_SETUP;
                    end
                    else
                    begin
                        dp_cmd.row_next = 1'b1;
                        state_next      = ST_ROW_FETCH;
                    end
                end
            end
            ST_DIV_SETUP:
            begin
                dp_cmd.div_setup = 1'b1;
                state_next       = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                dp_cmd.div_step = 1'b1;
                if (dp_stat.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register can take the result
                if (dp_stat.out_free)
                begin
                    dp_cmd.out_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/edsu_dp.sv =====
// Datapath: word stores, DP cost row, serial divider and output register.
module edsu_dp
    import edsu_pkg::*;
#(
    parameter int MAX_LEN = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           dp_cmd,
    output dp_stat_t          dp_stat,
    input  logic [7:0]        char_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DIST_W-1:0] distance,
    output logic [SIM_W-1:0]  similarity,
    output logic              overflow
);

    localparam int LW  = $clog2(MAX_LEN + 1);
    localparam int WAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int TW  = LW + 1;
    localparam int NW  = TW + FRAC_W;
    localparam int CW  = $clog2(NW + 1);

    logic [LW-1:0]  len1_reg, len2_reg;
    logic           ovf_reg;
    logic [LW-1:0]  i_reg, j_reg;
    logic [LW-1:0]  left_reg, diag_reg;
    logic [LW-1:0]  dist_reg;
    logic [TW-1:0]  total_reg;
    logic [TW:0]    rem_reg;
    logic [NW-1:0]  quo_reg;
    logic [CW-1:0]  cnt_reg;
    logic              out_valid_reg;
    logic [DIST_W-1:0] distance_reg;
    logic [SIM_W-1:0]  similarity_reg;
    logic              overflow_reg;

    logic [7:0]     w1_rdata, w2_rdata;
    logic [LW-1:0]  cost_rdata;
    logic           len1_full, len2_full;
    logic           col_last;
    logic [LW-1:0]  i_minus1, j_plus1;
    logic [LW-1:0]  above, best, cell_val;
    logic [LW-1:0]  dist_sel;
    logic [TW-1:0]  total;
    logic [TW:0]    rem_sh;
    logic           q_bit;
    logic           out_fire;

    assign len1_full = (len1_reg == LW'(MAX_LEN));
    assign len2_full = (len2_reg == LW'(MAX_LEN));
    assign col_last  = (j_reg == len2_reg);
    assign i_minus1  = i_reg - LW'(1);
    assign j_plus1   = j_reg + LW'(1);
    assign out_fire  = out_valid_reg && !out_stall;

    edsu_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_first_word (
        .clk   (clk),
        .we    (dp_cmd.load_first && !len1_full),
        .waddr (len1_reg[WAW-1:0]),
        .wdata (char_byte),
        .re    (dp_cmd.row_fetch),
        .raddr (i_minus1[WAW-1:0]),
        .rdata (w1_rdata)
    );

    // column j+1 compares against byte j of the second word
    edsu_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_second_word (
        .clk   (clk),
        .we    (dp_cmd.load_second && !len2_full),
        .waddr (len2_reg[WAW-1:0]),
        .wdata (char_byte),
        .re    (dp_cmd.row_fetch || (dp_cmd.calc && !col_last)),
        .raddr (dp_cmd.row_fetch ? WAW'(0) : j_reg[WAW-1:0]),
        .rdata (w2_rdata)
    );

    edsu_ram #(.WIDTH(LW), .DEPTH(MAX_LEN + 1)) u_cost_row (
        .clk   (clk),
        .we    (dp_cmd.calc),
        .waddr (j_reg),
        .wdata (cell_val),
        .re    (dp_cmd.row_fetch || (dp_cmd.calc && !col_last)),
        .raddr (dp_cmd.row_fetch ? LW'(1) : j_plus1),
        .rdata (cost_rdata)
    );

    // first row: the previous row is the implicit 0..n2 ramp
    always_comb
    begin
        above = (i_reg == LW'(1)) ? j_reg : cost_rdata;
        best  = diag_reg;
        if (above < best)
        begin
            best = above;
        end
        if (left_reg < best)
        begin
            best = left_reg;
        end
        if (w1_rdata == w2_rdata)
        begin
            cell_val = diag_reg;
        end
        else
        begin
            cell_val = best + LW'(1);
        end
    end

    always_comb
    begin
        if (len1_reg == '0)
        begin
            dist_sel = len2_reg;
        end
        else if (len2_reg == '0)
        begin
            dist_sel = len1_reg;
        end
        else
        begin
            dist_sel = left_reg;
        end
        total  = TW'(len1_reg) + TW'(len2_reg);
        rem_sh = {rem_reg[TW-1:0], quo_reg[NW-1]};
        q_bit  = (rem_sh >= {1'b0, total_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len1_reg      <= '0;
            len2_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (dp_cmd.load_first)
            begin
                if (len1_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    len1_reg <= len1_reg + LW'(1);
                end
            end
            if (dp_cmd.load_second)
            begin
                if (len2_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    len2_reg <= len2_reg + LW'(1);
                end
            end
            if (dp_cmd.out_load)
            begin
                len1_reg      <= '0;
                len2_reg      <= '0;
                ovf_reg       <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.start)
        begin
            i_reg <= LW'(1);
        end
        else if (dp_cmd.row_next)
        begin
            i_reg <= i_reg + LW'(1);
        end

        if (dp_cmd.row_fetch)
        begin
            j_reg    <= LW'(1);
            left_reg <= i_reg;
            diag_reg <= i_minus1;
        end
        else if (dp_cmd.calc)
        begin
            j_reg    <= j_plus1;
            left_reg <= cell_val;
            diag_reg <= above;
        end

        if (dp_cmd.div_setup)
        begin
            dist_reg  <= dist_sel;
            total_reg <= total;
            rem_reg   <= '0;
            quo_reg   <= {total - TW'(dist_sel), {FRAC_W{1'b0}}};
            cnt_reg   <= '0;
        end
        else if (dp_cmd.div_step)
        begin
            rem_reg <= q_bit ? (rem_sh - {1'b0, total_reg}) : rem_sh;
            quo_reg <= {quo_reg[NW-2:0], q_bit};
            cnt_reg <= cnt_reg + CW'(1);
        end

        if (dp_cmd.out_load)
        begin
            distance_reg   <= DIST_W'(dist_reg);
            similarity_reg <= (total_reg == '0) ? SIM_W'(1 << FRAC_W) : quo_reg[SIM_W-1:0];
            overflow_reg   <= ovf_reg;
        end
    end

    assign dp_stat.first_empty  = (len1_reg == '0);
    assign dp_stat.second_empty = (len2_reg == '0);
    assign dp_stat.col_last     = col_last;
    assign dp_stat.row_last     = (i_reg == len1_reg);
    assign dp_stat.div_last     = (cnt_reg == CW'(NW - 1));
    assign dp_stat.out_free     = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign distance   = distance_reg;
    assign similarity = similarity_reg;
    assign overflow   = overflow_reg;

endmodule

// ===== rtl/edit_distance_similarity_unit.sv =====
// Usage notes:
// Input channel (in_valid/in_stall, cmd, char_byte): cmd FIRST or SECOND appends
// char_byte to that word; a byte past MAX_LEN is dropped and sets the overflow
// flag. cmd COMPUTE finds the edit distance and similarity, then clears both words.
// Unused cmd codes are taken and ignored.
// Output channel (out_valid/out_stall, distance, similarity, overflow): one item
// per COMPUTE; similarity is 16-bit fraction fixed point, 65536 means 1.0.
// Rate: load items are accepted back to back while the block is idle. A COMPUTE item
// holds in_stall high through the DP sweep (skipped if either word is empty; one cell
// per cycle within a row through the cost-row RAM), the bit-serial divider and the
// load of the output register.
// When the receiver stalls, the result holds in the output register; loads keep
// flowing, and a following COMPUTE finishes its work and waits for the register.
// Reset clears lengths, the overflow flag and the output valid; word contents
// are not cleared.
module edit_distance_similarity_unit
    import edsu_pkg::*;
#(
    parameter int MAX_LEN = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        cmd,
    input  logic [7:0]        char_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DIST_W-1:0] distance,
    output logic [SIM_W-1:0]  similarity,
    output logic              overflow
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    edsu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .in_stall (in_stall),
        .dp_cmd   (dp_cmd),
        .dp_stat  (dp_stat)
    );

    edsu_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .dp_stat    (dp_stat),
        .char_byte  (char_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .distance   (distance),
        .similarity (similarity),
        .overflow   (overflow)
    );

endmodule

// ===== rtl/edsu_checker.sv =====
// Port-level checks for the edit distance similarity unit, bound to the top level.
module edsu_checker
    import edsu_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic [1:0]        cmd,
    input logic [7:0]        char_byte,
    input logic              out_valid,
    input logic              out_stall,
    input logic [DIST_W-1:0] distance,
    input logic [SIM_W-1:0]  similarity,
    input logic              overflow
);

    // a stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(distance)
            && $stable(similarity) && $stable(overflow))
        else $error("stalled result item changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> similarity <= SIM_W'(1 << FRAC_W))
        else $error("similarity above 1.0");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (similarity == SIM_W'(1 << FRAC_W)) |-> distance == '0)
        else $error("full similarity with nonzero distance");

    // a compute item keeps the block busy the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == CMD_COMPUTE) |=> in_stall)
        else $error("compute item did not start work");

endmodule

bind edit_distance_similarity_unit edsu_checker u_edsu_checker (.*);

// ===== test/testbench.sv =====
// Self-checking testbench for the edit distance similarity unit.
module testbench;
    import edsu_pkg::*;

    localparam int          MAX_LEN      = 32;
    localparam int          RANDOM_ITEMS = 1150;
    localparam int          QUIET_ITEMS  = 150;
    localparam int          STALL_LIMIT  = 5000;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0] edits;
        logic [SIM_W-1:0]  sim;
        logic              ovf;
    } score_t;

    typedef struct {
        logic [1:0] op;
        logic [7:0] data;
        int         reps;
        bit         typed;
        score_t     want;
    } step_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        cmd = CMD_FIRST;
    logic [7:0]        char_byte = 8'h00;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DIST_W-1:0] distance;
    logic [SIM_W-1:0]  similarity;
    logic              overflow;

    // Predictor state
    logic [7:0]  word_a [0:MAX_LEN-1];
    logic [7:0]  word_b [0:MAX_LEN-1];
    int unsigned len_a = 0;
    int unsigned len_b = 0;
    logic        truncated = 1'b0;

    score_t      pending_scores [$];
    step_row_t   directed_steps [$];
    int          items_sent = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;
    bit          bursty = 1'b1;

    edit_distance_similarity_unit #(.MAX_LEN(MAX_LEN)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .char_byte  (char_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .distance   (distance),
        .similarity (similarity),
        .overflow   (overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Single-row Levenshtein sweep over the loaded words
    function automatic score_t levenshtein_score();
        int unsigned row [0:MAX_LEN];
        int unsigned diag;
        int unsigned above;
        int unsigned best;
        int unsigned total;
        score_t      sc;
        for (int j = 0; j <= len_b; j++)
            row[j] = j;
        for (int i = 1; i <= len_a; i++)
        begin
            diag   = row[0];
            row[0] = i;
            for (int j = 1; j <= len_b; j++)
            begin
                above = row[j];
                if (word_a[i-1] == word_b[j-1])
                    row[j] = diag;
                else
                begin
                    best = diag;
                    if (above < best)
                        best = above;
                    if (row[j-1] < best)
                        best = row[j-1];
                    row[j] = best + 1;
                end
                diag = above;
            end
        end
        total    = len_a + len_b;
        sc.edits = DIST_W'(row[len_b]);
        if (total == 0)
            sc.sim = 17'd65536;
        else
            sc.sim = SIM_W'(((total - row[len_b]) << 16) / total);
        sc.ovf  = truncated;
        return sc;
    endfunction

    task automatic plan(input logic [1:0] op, input logic [7:0] data, input int reps,
                        input bit typed, input int d, input int s, input bit o);
        step_row_t r;
        r.op         = op;
        r.data       = data;
        r.reps       = reps;
        r.typed      = typed;
        r.want.edits = DIST_W'(d);
        r.want.sim   = SIM_W'(s);
        r.want.ovf   = o;
        directed_steps.push_back(r);
    endtask

    // Drive one item, wait for it to be taken, update the predictor, maybe rest
    task automatic send(input logic [1:0] c, input logic [7:0] b, input bit typed,
                        input score_t want);
        score_t sc;
        in_valid  <= 1'b1;
        cmd       <= c;
        char_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        if (c == CMD_FIRST)
        begin
            if (len_a < MAX_LEN)
            begin
                word_a[len_a] = b;
                len_a++;
            end
            else
                truncated = 1'b1;
        end
        else if (c == CMD_SECOND)
        begin
            if (len_b < MAX_LEN)
            begin
                word_b[len_b] = b;
                len_b++;
            end
            else
                truncated = 1'b1;
        end
        else if (c == CMD_COMPUTE)
        begin
            sc = levenshtein_score();
            pending_scores.push_back(typed ? want : sc);
            len_a     = 0;
            len_b     = 0;
            truncated = 1'b0;
        end
        if (c != CMD_UNUSED)
            items_sent++;
        if (!quiet && bursty && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // Hold the input side until every pending score is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_scores.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        step_row_t   r;
        logic [7:0]  syms_a [$];
        logic [7:0]  syms_b [$];
        logic [7:0]  base;
        int          span;
        int          n_a;
        int          n_b;
        int          ia;
        int          ib;
        int          pos;
        bit          drained;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty words right after reset
        plan(CMD_COMPUTE, 8'h00, 1, 1, 0, 65536, 0);
        // Zero byte is a character; compute ignores its byte
        plan(CMD_FIRST,   8'h00, 1, 0, 0, 0, 0);
        plan(CMD_FIRST,   8'hFF, 1, 0, 0, 0, 0);
        plan(CMD_COMPUTE, 8'hFF, 1, 1, 2, 0, 0);
        plan(CMD_SECOND,  8'h00, 1, 0, 0, 0, 0);
        plan(CMD_FIRST,   8'h00, 1, 0, 0, 0, 0);
        plan(CMD_COMPUTE, 8'h00, 1, 1, 0, 65536, 0);
        // Unused code leaves the words alone
        plan(CMD_UNUSED,  8'hFF, 1, 0, 0, 0, 0);
        plan(CMD_UNUSED,  8'h00, 1, 0, 0, 0, 0);
        plan(CMD_COMPUTE, 8'h00, 1, 1, 0, 65536, 0);
        plan(CMD_SECOND,  8'h80, 1, 0, 0, 0, 0);
        plan(CMD_FIRST,   8'h7F, 1, 0, 0, 0, 0);
        plan(CMD_FIRST,   8'h80, 1, 0, 0, 0, 0);
        plan(CMD_COMPUTE, 8'h00, 1, 0, 0, 0, 0);
        // Word full: one byte too many on the first word
        plan(CMD_FIRST,   8'h5A, MAX_LEN + 1, 0, 0, 0, 0);
        plan(CMD_COMPUTE, 8'h00, 1, 1, 32, 0, 1);
        // Longest words, nothing in common
        plan(CMD_SECOND,  8'h00, MAX_LEN + 1, 0, 0, 0, 0);
        plan(CMD_FIRST,   8'hFF, MAX_LEN, 0, 0, 0, 0);
        plan(CMD_COMPUTE, 8'h00, 1, 1, 32, 32768, 1);
        // Both words exactly full and equal
        plan(CMD_FIRST,   8'h41, MAX_LEN, 0, 0, 0, 0);
        plan(CMD_SECOND,  8'h41, MAX_LEN, 0, 0, 0, 0);
        plan(CMD_COMPUTE, 8'h00, 1, 1, 0, 65536, 0);
        plan(CMD_SECOND,  8'h55, 3, 0, 0, 0, 0);
        plan(CMD_FIRST,   8'h55, 1, 0, 0, 0, 0);
        plan(CMD_COMPUTE, 8'h00, 1, 0, 0, 0, 0);

        foreach (directed_steps[k])
        begin
            r = directed_steps[k];
            repeat (r.reps) send(r.op, r.data, r.typed, r.want);
        end
        drain();

        items_sent = 0;
        drained    = 1'b0;
        while (items_sent < RANDOM_ITEMS)
        begin
            bursty = 1'($urandom_range(0, 1));
            if (items_sent > RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            if (!drained && items_sent > RANDOM_ITEMS / 2)
            begin
                drain();
                drained = 1'b1;
            end

            // Mostly short words over a small alphabet so that matches occur
            if ($urandom_range(0, 9) == 0)
            begin
                n_a = $urandom_range(20, MAX_LEN + 4);
                n_b = $urandom_range(20, MAX_LEN + 4);
            end
            else
            begin
                n_a = $urandom_range(0, 8);
                n_b = $urandom_range(0, 8);
            end
            base = 8'($urandom);
            span = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 3);
            syms_a.delete();
            syms_b.delete();
            repeat (n_a) syms_a.push_back(8'(base + $urandom_range(0, span)));
            if ($urandom_range(0, 1) == 0)
            begin
                // Second word is a lightly edited copy of the first
                syms_b = syms_a;
                repeat ($urandom_range(0, 3))
                begin
                    pos = $urandom_range(0, syms_b.size());
                    case ($urandom_range(0, 2))
                        0:
                            if (pos < syms_b.size())
                                syms_b[pos] = 8'(base + $urandom_range(0, span));
                        1: if (pos < syms_b.size()) syms_b.delete(pos);
                        default: syms_b.insert(pos, 8'(base + $urandom_range(0, span)));
                    endcase
                end
            end
            else
                repeat (n_b) syms_b.push_back(8'(base + $urandom_range(0, span)));

            ia = 0;
            ib = 0;
            while (ia < syms_a.size() || ib < syms_b.size())
            begin
                if ($urandom_range(0, 24) == 0)
                    send(CMD_UNUSED, 8'($urandom), 1'b0, '0);
                else if (ib >= syms_b.size() || (ia < syms_a.size() && $urandom_range(0, 1)))
                begin
                    send(CMD_FIRST, syms_a[ia], 1'b0, '0);
                    ia++;
                end
                else
                begin
                    send(CMD_SECOND, syms_b[ib], 1'b0, '0);
                    ib++;
                end
            end
            send(CMD_COMPUTE, 8'($urandom), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Output stall in bursts, none in the closing stretch
    initial
    begin
        forever
        begin
            repeat ($urandom_range(1, 60)) @(posedge clk);
            if (!quiet)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        score_t got;
        score_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.edits = distance;
            got.sim   = similarity;
            got.ovf   = overflow;
            if (pending_scores.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at %0t: %s %0d %s %0d %s %0d",
                             $time, "distance", got.edits, "similarity", got.sim,
                             "overflow", got.ovf);
            end
            else
            begin
                want = pending_scores.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: %s %0d/%0d %s %0d/%0d %s %0d/%0d %s",
                                 $time, "distance", want.edits, got.edits,
                                 "similarity", want.sim, got.sim,
                                 "overflow", want.ovf, got.ovf, "(expected/actual)");
                end
            end
        end
    end

    // Watchdog: cycles with no item taken on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
